>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/lzsswd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS window decompressor package
// Constants, sequencer states and the window access request type.
// ----------------------------------------------------------------------------
`default_nettype none

package lzsswd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int ADDR_W      = $clog2(WINDOW_SIZE);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int CNT_W       = 5;

    localparam logic [ADDR_W-1:0] START_POS  = ADDR_W'(4078);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WINDOW_SIZE);
    localparam logic [CNT_W-1:0]  LEN_BIAS   = CNT_W'(3);
    localparam logic [15:0]       FLAG_FILL  = 16'hFF00;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clear;
    } t_win_req;

endpackage

`default_nettype wire

>>> sv/lzsswd_if.sv
// ----------------------------------------------------------------------------
// LZSS window decompressor channels
// Valid/ready channels for compressed input bytes and decompressed output.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzsswd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
    modport mon    (input valid, input in_byte, input in_last, input ready);
endinterface

interface lzsswd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
    modport mon    (input valid, input out_byte, input out_last, input ready);
endinterface

`default_nettype wire

>>> sv/lzsswd_window.sv
// ----------------------------------------------------------------------------
// LZSS history window
// 4096-byte single-port-style window with registered read and a fill count
// that makes never-written entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lzsswd_window (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lzsswd_pkg::t_win_req       i_req,
    output logic [7:0]                      o_rd_byte
);

    logic [7:0]                      r_mem [lzsswd_pkg::WINDOW_SIZE];
    logic [7:0]                      r_rd_data;
    logic                            r_rd_hit;
    logic [lzsswd_pkg::FILL_W-1:0]   r_fill;
    logic [lzsswd_pkg::FILL_W-1:0]   n_fill;
    logic [lzsswd_pkg::ADDR_W-1:0]   rd_offs;
    logic                            rd_hit;

    // Writes run strictly in sequence from the start position, so an entry
    // holds real data exactly when its offset from there is below the fill.
    assign rd_offs = i_req.rd_addr - lzsswd_pkg::START_POS;
    assign rd_hit  = {1'b0, rd_offs} < r_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_req.clear) begin
            n_fill = '0;
        end else if (i_req.wr_en && (r_fill != lzsswd_pkg::FILL_FULL)) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_hit  <= rd_hit;
        end
    end

    assign o_rd_byte = r_rd_hit ? r_rd_data : 8'h00;

endmodule

`default_nettype wire

>>> sv/lzsswd_ctrl.sv
// ----------------------------------------------------------------------------
// LZSS parse sequencer
// Parses flag, literal and reference bytes and steps the copy loop one byte
// at a time through the shared window port, feeding an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzsswd_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    lzsswd_in_if.sink                   i_in,
    lzsswd_out_if.source                o_out,
    output lzsswd_pkg::t_win_req        o_win,
    input  wire logic [7:0]             i_rd_byte
);

    lzsswd_pkg::t_state                 r_state, n_state;
    logic [15:0]                        r_flag, n_flag;
    logic                               r_phase, n_phase;
    logic [7:0]                         r_ref_low, n_ref_low;
    logic [lzsswd_pkg::ADDR_W-1:0]      r_wpos, n_wpos;
    logic                               r_last_pend, n_last_pend;
    logic                               r_out_valid, n_out_valid;
    logic [lzsswd_pkg::ADDR_W-1:0]      r_src, n_src;
    logic [lzsswd_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [7:0]                         r_out_byte, n_out_byte;
    logic                               r_out_last, n_out_last;
    logic                               out_free;
    logic                               accept;
    logic                               do_reset;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == lzsswd_pkg::S_IDLE) && out_free;
    assign accept     = i_in.valid && i_in.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.out_last = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_flag      = r_flag;
        n_phase     = r_phase;
        n_ref_low   = r_ref_low;
        n_wpos      = r_wpos;
        n_last_pend = r_last_pend;
        n_src       = r_src;
        n_cnt       = r_cnt;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !o_out.ready;
        do_reset    = 1'b0;

        o_win         = '0;
        o_win.rd_addr = r_src;
        o_win.wr_addr = r_wpos;
        o_win.wr_data = i_rd_byte;

        case (r_state)
            lzsswd_pkg::S_IDLE: begin
                if (accept) begin
                    if (r_phase) begin
                        // second reference byte: start the copy
                        n_src       = {i_in.in_byte[7:4], r_ref_low};
                        n_cnt       = lzsswd_pkg::CNT_W'({1'b0, i_in.in_byte[3:0]})
                                      + lzsswd_pkg::LEN_BIAS;
                        n_last_pend = i_in.in_last;
                        n_state     = lzsswd_pkg::S_READ;
                    end else if (!r_flag[8]) begin
                        n_flag   = lzsswd_pkg::FLAG_FILL | {8'h00, i_in.in_byte};
                        do_reset = i_in.in_last;
                    end else if (r_flag[0]) begin
                        o_win.wr_en   = 1'b1;
                        o_win.wr_data = i_in.in_byte;
                        n_wpos        = r_wpos + 1'b1;
                        n_out_valid   = 1'b1;
                        n_out_byte    = i_in.in_byte;
                        n_out_last    = 1'b1;
                        n_flag        = {1'b0, r_flag[15:1]};
                        do_reset      = i_in.in_last;
                    end else begin
                        n_ref_low = i_in.in_byte;
                        n_phase   = 1'b1;
                        do_reset  = i_in.in_last;
                    end
                end
            end
            lzsswd_pkg::S_READ: begin
                o_win.rd_en = 1'b1;
                n_state     = lzsswd_pkg::S_EMIT;
            end
            lzsswd_pkg::S_EMIT: begin
                // hold the read byte until the output register frees up
                if (out_free) begin
                    o_win.wr_en = 1'b1;
                    n_wpos      = r_wpos + 1'b1;
                    n_src       = r_src + 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = i_rd_byte;
                    n_out_last  = (r_cnt == lzsswd_pkg::CNT_W'(1));
                    if (r_cnt == lzsswd_pkg::CNT_W'(1)) begin
                        n_flag   = {1'b0, r_flag[15:1]};
                        n_phase  = 1'b0;
                        n_state  = lzsswd_pkg::S_IDLE;
                        do_reset = r_last_pend;
                    end else begin
                        n_state = lzsswd_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = lzsswd_pkg::S_IDLE;
            end
        endcase

        // end of stream: drop parse state and empty the window
        if (do_reset) begin
            n_flag      = '0;
            n_phase     = 1'b0;
            n_ref_low   = '0;
            n_wpos      = lzsswd_pkg::START_POS;
            n_last_pend = 1'b0;
            o_win.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzsswd_pkg::S_IDLE;
            r_flag      <= '0;
            r_phase     <= 1'b0;
            r_ref_low   <= '0;
            r_wpos      <= lzsswd_pkg::START_POS;
            r_last_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flag      <= n_flag;
            r_phase     <= n_phase;
            r_ref_low   <= n_ref_low;
            r_wpos      <= n_wpos;
            r_last_pend <= n_last_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_cnt      <= n_cnt;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire

>>> sv/lzss_window_decompressor.sv
// ----------------------------------------------------------------------------
// LZSS window decompressor
// Decodes an LZSS stream with a 4096-byte window, one compressed byte per
// transaction, into decompressed bytes.
// ----------------------------------------------------------------------------
// Flag bytes and first reference bytes produce nothing; a literal produces
// one byte. A second reference byte produces its 3 to 18 bytes: each copied
// byte is one window read followed by one window write through the single
// window port, so that overlapping copies see their own output. The input is
// not ready during a copy or while the output register holds an untaken byte.
// A transaction with in_last set ends the stream; the block then starts over
// with an empty window at once, since a fill count, not a clearing pass,
// tracks which window entries hold data.
`default_nettype none

module lzss_window_decompressor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lzsswd_in_if.sink       i_in,
    lzsswd_out_if.source    o_out
);

    lzsswd_pkg::t_win_req   win_req;
    logic [7:0]             rd_byte;

    lzsswd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_win     (win_req),
        .i_rd_byte (rd_byte)
    );

    lzsswd_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (win_req),
        .o_rd_byte (rd_byte)
    );

endmodule

`default_nettype wire

>>> sv/lzsswd_checker.sv
// ----------------------------------------------------------------------------
// LZSS window decompressor checker
// Port-level checks on the output channel and its coupling to the input.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzsswd_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lzsswd_in_if.sink       i_in,
    lzsswd_out_if.source    i_out
);

    logic       out_stall;
    logic [8:0] out_word;

    assign out_stall = i_out.valid && !i_out.ready;
    assign out_word  = {i_out.out_byte, i_out.out_last};

    `ASSERT_CLK_ALWAYS(a_rst_out_idle, i_clk, !i_rst_n |=> !i_out.valid, "valid after reset")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out.valid, "output valid dropped")
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(out_word), "output changed")
    `ASSERT_CLK(a_in_blocked, i_clk, i_rst_n, out_stall |-> !i_in.ready, "input ready on stall")

endmodule

bind lzss_window_decompressor lzsswd_checker u_lzsswd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .i_out   (o_out)
);

`default_nettype wire
